[rtl/wavhv_pkg.sv]
// Package for the WAV header stream validator.
// Holds tags, sizes, divider widths and the format struct; no dependencies.
`default_nettype none
package wavhv_pkg;

  localparam logic [31:0] TagRiff = 32'h52494646;
  localparam logic [31:0] TagWave = 32'h57415645;
  localparam logic [31:0] TagFmt  = 32'h666D7420;
  localparam logic [31:0] TagData = 32'h64617461;

  localparam int unsigned RiffHdrBytes  = 12;
  localparam int unsigned ChunkHdrBytes = 8;
  localparam int unsigned FmtMinBytes   = 16;

  localparam logic [33:0] PosMax = 34'h3FFFFFFFF;

  localparam int unsigned QuotW = 48;
  localparam int unsigned DivdW = 48;
  localparam int unsigned RemW  = 33;

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_bytes;
  } fmt_t;

endpackage
`default_nettype wire

[rtl/wav_header_stream_validator_unit.sv]
// WAV header stream validator top level: byte parser plus verdict sequencer.
// Depends on wavhv_pkg and wavhv_divider.
// After the tlast transfer the verdict sequencer registers the channel by sample size
// product, checks the format, then for a file that passes runs the divider twice:
// data size by block align, then the duration. A file whose data size is not a
// multiple of block align skips the second division; any other rejected file skips both.
// Throughput: one byte per cycle inside a file; input held while the verdict is built.
// Reset: asynchronous, active low; clears parser state and the output valid.
`default_nettype none
module wav_header_stream_validator_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte
  input  wire logic         s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [199:0]      m_axis_tdata,
  // ok, channels, sample_rate, byte_rate, block_align, bits_per_sample,
  // data_bytes, duration_q16, 7 zero bits
  output logic              m_axis_tlast
);

  typedef enum logic [2:0] {
    PhRiff, PhChdr, PhFmt, PhSkip, PhDone
  } phase_e;

  typedef enum logic [2:0] {
    StIn, StMul, StChk, StRem, StWRem, StDur, StWDur, StOut
  } state_e;

  phase_e          ph_q, ph_d;
  state_e          st_q, st_d;
  logic [33:0]     pos_q, pos_d;
  logic [32:0]     rend_q, rend_d;
  logic [32:0]     crem_q, crem_d;
  logic [31:0]     tag_q, tag_d;
  logic [31:0]     fa_q, fa_d;
  logic [127:0]    ff_q, ff_d;
  logic [31:0]     dsz_q, dsz_d;
  logic            fseen_q, fseen_d, fail_q, fail_d;
  logic            ok_q, ok_d;
  logic            ovld_q, ovld_d;
  logic [199:0]    out_q, out_d;
  logic [63:0]     prod_q, prod_d;

  logic [15:0] f_fmt, f_ch, f_align, f_bits;
  logic [31:0] f_rate, f_brate;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic                          dv_start, dv_busy, dv_done;
  logic [wavhv_pkg::DivdW-1:0]   dv_num, dv_quot;
  logic [31:0]                   dv_den, dv_rem;

  logic        acc;
  logic [33:0] idx;
  logic [7:0]  b;

  assign f_fmt   = ff_q[15:0];
  assign f_ch    = ff_q[31:16];
  assign f_rate  = ff_q[63:32];
  assign f_brate = ff_q[95:64];
  assign f_align = ff_q[111:96];
  assign f_bits  = ff_q[127:112];

  always_comb begin
    if (st_q == StMul) begin
      mul_a = {16'd0, f_ch};
      mul_b = {19'd0, f_bits[15:3]};
    end else begin
      mul_a = f_rate;
      mul_b = {16'd0, f_align};
    end
    mul_p = mul_a * mul_b;
  end

  wavhv_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  assign s_axis_tready = (st_q == StIn);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;
  assign idx = pos_q;

  always_comb begin
    logic [32:0] pad;
    logic [34:0] endp;
    logic [31:0] sz;
    logic        nc;
    pad  = '0;
    endp = '0;
    sz   = '0;
    nc   = 1'b0;
    ph_d = ph_q; pos_d = pos_q; rend_d = rend_q; crem_d = crem_q;
    tag_d = tag_q; fa_d = fa_q; ff_d = ff_q; dsz_d = dsz_q;
    fseen_d = fseen_q; fail_d = fail_q; st_d = st_q; ok_d = ok_q;
    ovld_d = ovld_q; out_d = out_q; prod_d = prod_q;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (st_q)
      StIn: begin
        if (acc) begin
          if (!fail_q) begin
            if (pos_q < wavhv_pkg::PosMax) pos_d = pos_q + 34'd1;
            unique case (ph_q)
              PhRiff: begin
                tag_d = {tag_q[23:0], b};
                if (idx >= 34'd4 && idx < 34'd8) fa_d = {b, fa_q[31:8]};
                if (idx == 34'd3 && tag_d != wavhv_pkg::TagRiff) fail_d = 1'b1;
                if (idx == 34'(wavhv_pkg::RiffHdrBytes - 1)) begin
                  if (tag_d != wavhv_pkg::TagWave || fa_q < 32'd4) fail_d = 1'b1;
                  else begin
                    rend_d = {1'b0, fa_q} + 33'd8;
                    nc = 1'b1;
                  end
                end
              end
              PhChdr: begin
                if (crem_q > 33'd4) tag_d = {tag_q[23:0], b};
                else fa_d = {b, fa_q[31:8]};
                crem_d = crem_q - 33'd1;
                if (crem_d == 33'd0) begin
                  sz   = fa_d;
                  pad  = {1'b0, sz} + {32'd0, sz[0]};
                  endp = {1'b0, pos_d} + {2'b00, pad};
                  if (endp > {2'b00, rend_q}) fail_d = 1'b1;
                  else begin
                    crem_d = pad;
                    fa_d = '0;
                    if (tag_d == wavhv_pkg::TagFmt && sz >= 32'(wavhv_pkg::FmtMinBytes)
                        && !fseen_q) begin
                      ph_d = PhFmt;
                    end else if (tag_d == wavhv_pkg::TagData &&
                                 (sz == 32'd0 || dsz_q != 32'd0)) begin
                      fail_d = 1'b1;
                    end else begin
                      if (tag_d == wavhv_pkg::TagData) dsz_d = sz;
                      ph_d = PhSkip;
                      if (pad == 33'd0) nc = 1'b1;
                    end
                  end
                end
              end
              PhFmt: begin
                if (fa_q < 32'(wavhv_pkg::FmtMinBytes)) begin
                  ff_d[{fa_q[3:0], 3'b000} +: 8] = b;
                  fa_d = fa_q + 32'd1;
                  if (fa_d == 32'(wavhv_pkg::FmtMinBytes)) begin
                    // format is checked in the verdict sequence after tlast; fold into fseen
                    fseen_d = 1'b1;
                  end
                end
                if (crem_q != 33'd0) crem_d = crem_q - 33'd1;
                if (crem_d == 33'd0) nc = 1'b1;
              end
              PhSkip: begin
                if (crem_q != 33'd0) crem_d = crem_q - 33'd1;
                if (crem_d == 33'd0) nc = 1'b1;
              end
              default: ;
            endcase
            if (nc) begin
              if ({1'b0, pos_d} == {2'b00, rend_d}) ph_d = PhDone;
              else if ({1'b0, pos_d} > {2'b00, rend_d} ||
                       ({2'b00, rend_d} - {1'b0, pos_d}) < 35'(wavhv_pkg::ChunkHdrBytes))
                fail_d = 1'b1;
              else begin
                ph_d = PhChdr;
                crem_d = 33'(wavhv_pkg::ChunkHdrBytes);
                tag_d = '0;
                fa_d = '0;
              end
            end
          end
          if (s_axis_tlast) st_d = StMul;
        end
      end
      StMul: begin
        prod_d = mul_p;
        st_d = StChk;
      end
      StChk: begin
        ok_d = !fail_q && ph_q == PhDone && fseen_q && dsz_q != 32'd0 &&
               f_fmt == 16'd1 && f_ch != 16'd0 && f_rate != 32'd0 &&
               f_bits != 16'd0 && f_bits[2:0] == 3'd0 && prod_q[31:0] != 32'd0 &&
               prod_q[63:16] == 48'd0 && f_align == prod_q[15:0] &&
               mul_p[63:32] == 32'd0 && f_brate == mul_p[31:0];
        st_d = StRem;
      end
      StRem: begin
        if (ok_q) begin
          dv_start = 1'b1;
          dv_num = {16'd0, dsz_q};
          dv_den = {16'd0, f_align};
          st_d = StWRem;
        end else st_d = StOut;
      end
      StWRem: begin
        if (dv_done) begin
          if (dv_rem != 32'd0) ok_d = 1'b0;
          st_d = StDur;
        end
      end
      StDur: begin
        if (ok_q) begin
          dv_start = 1'b1;
          dv_num = {dsz_q, 16'd0};
          dv_den = f_brate;
          st_d = StWDur;
        end else st_d = StOut;
      end
      StWDur: if (dv_done) st_d = StOut;
      StOut: begin
        if (!ovld_q) begin
          ovld_d = 1'b1;
          if (ok_q)
            out_d = {7'd0, dv_quot, dsz_q, f_bits, f_align, f_brate, f_rate, f_ch, 1'b1};
          else out_d = '0;
          st_d = StIn;
          ph_d = PhRiff; pos_d = '0; rend_d = '0; crem_d = '0; tag_d = '0;
          fa_d = '0; ff_d = '0; dsz_d = '0; fseen_d = 1'b0; fail_d = 1'b0;
          ok_d = 1'b0;
        end
      end
      default: st_d = StIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIn; ph_q <= PhRiff; pos_q <= '0; rend_q <= '0; crem_q <= '0;
      tag_q <= '0; fa_q <= '0; ff_q <= '0; dsz_q <= '0; fseen_q <= 1'b0;
      fail_q <= 1'b0; ok_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; pos_q <= pos_d; rend_q <= rend_d; crem_q <= crem_d;
      tag_q <= tag_d; fa_q <= fa_d; ff_q <= ff_d; dsz_q <= dsz_d; fseen_q <= fseen_d;
      fail_q <= fail_d; ok_q <= ok_d; ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    prod_q <= prod_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = 1'b1;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIn) |-> !s_axis_tready) else $error("accept while busy");
  a_div_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIn) |-> !dv_busy) else $error("divider busy while parsing");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> (st_q == StMul)) else $error("verdict not started");

endmodule
`default_nettype wire

[rtl/wavhv_divider.sv]
// Restoring divider: one quotient bit per cycle while busy, shared for all division work.
// Depends on wavhv_pkg.
`default_nettype none
module wavhv_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [wavhv_pkg::DivdW-1:0]  dividend_i,
  input  wire logic [31:0]                  divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [wavhv_pkg::QuotW-1:0]       quot_o,
  output logic [31:0]                       rem_o
);

  logic [5:0]                      cnt_q, cnt_d;
  logic                            busy_q, busy_d, done_q, done_d;
  logic [wavhv_pkg::DivdW-1:0]     num_q, num_d;
  logic [wavhv_pkg::RemW-1:0]      rem_q, rem_d;
  logic [31:0]                     dvs_q, dvs_d;
  logic [wavhv_pkg::RemW-1:0]      trial;
  logic [wavhv_pkg::RemW:0]        diff;

  always_comb begin
    trial = {rem_q[wavhv_pkg::RemW-2:0], num_q[wavhv_pkg::DivdW-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_q};
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d = num_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 6'(wavhv_pkg::DivdW);
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[wavhv_pkg::RemW]) begin
        rem_d = trial;
        num_d = {num_q[wavhv_pkg::DivdW-2:0], 1'b0};
      end else begin
        rem_d = diff[wavhv_pkg::RemW-1:0];
        num_d = {num_q[wavhv_pkg::DivdW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q[31:0];

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for wav_header_stream_validator_unit: streams WAV files byte by byte and
// checks each verdict against a local parser of the RIFF/PCM rules or a typed verdict.
// Depends on wavhv_pkg and the validator RTL.
`default_nettype none
module tb;

  typedef enum logic [3:0] {PhRiff, PhChdr, PhFmt, PhSkip, PhDone} wav_phase_e;

  typedef struct {
    logic              ok;
    wavhv_pkg::fmt_t   fmt;
    logic [47:0]       dur;
  } verdict_t;

  typedef struct {
    logic [31:0] head_tag, wave_tag;
    int          p_force, p_adj;
    logic [15:0] code, ch, align, bits;
    logic [31:0] rate, brate;
    int          fmt_len, data_len, junk_len;
    bit          small_fmt, dup_data, no_fmt;
    int          keep, tail;
    bit          flip;
  } wav_spec_t;

  typedef struct {
    int name_ix;
    int ok_typed;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;  // data_byte
  logic         s_axis_tlast = 1'b0;  // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  // ok, channels, sample_rate, byte_rate, block_align, bits_per_sample,
  // data_bytes, duration_q16, zero fill
  logic         m_axis_tlast;

  wav_header_stream_validator_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  int          n_errors = 0;
  int          n_bytes = 0;
  int          n_files = 0;
  int          n_valid = 0;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;
  verdict_t    verdicts_due[$];
  int          typed_ok[$];

  // parser state
  wav_phase_e  ph;
  logic [63:0] pos, rend, rem;
  logic [31:0] tag, fa, dsize;
  logic [7:0]  ff[16];
  bit          seen, bad;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic void parser_clear();
    ph = PhRiff; pos = 0; rend = 0; rem = 0; tag = 0; fa = 0; dsize = 0;
    seen = 0; bad = 0;
    foreach (ff[i]) ff[i] = '0;
  endfunction

  function automatic logic [31:0] ff16(int i);
    return {16'h0, ff[(i + 1) & 15], ff[i & 15]};
  endfunction

  function automatic logic [31:0] ff32(int i);
    logic [31:0] lo, hi;
    lo = ff16(i);
    hi = ff16(i + 2);
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic void next_chunk();
    if (pos == rend) begin
      ph = PhDone;
      return;
    end
    if (pos > rend || rend - pos < wavhv_pkg::ChunkHdrBytes) begin
      bad = 1;
      return;
    end
    ph = PhChdr; rem = wavhv_pkg::ChunkHdrBytes; tag = 0; fa = 0;
  endfunction

  function automatic void end_chunk_header();
    logic [31:0] size;
    logic [63:0] padded;
    size = fa;
    padded = 64'(size) + 64'(size[0]);
    if (pos + padded > rend) begin
      bad = 1;
      return;
    end
    rem = padded;
    fa = 0;
    if (tag == wavhv_pkg::TagFmt && size >= wavhv_pkg::FmtMinBytes && !seen) begin
      ph = PhFmt;
      return;
    end
    if (tag == wavhv_pkg::TagData) begin
      if (size == 0 || dsize != 0) begin
        bad = 1;
        return;
      end
      dsize = size;
    end
    ph = PhSkip;
    if (padded == 0) next_chunk();
  endfunction

  function automatic void check_format();
    logic [31:0] code, ch, rate, brate, align, bits, want_align;
    logic [63:0] want_rate;
    code = ff16(0); ch = ff16(2); rate = ff32(4);
    brate = ff32(8); align = ff16(12); bits = ff16(14);
    want_align = ch * (bits / 8);
    want_rate = 64'(rate) * 64'(align);
    if (code != 1 || ch == 0 || rate == 0 || bits == 0 || bits % 8 != 0 ||
        want_align == 0 || align != want_align || want_rate > 64'hFFFFFFFF ||
        64'(brate) != want_rate) begin
      bad = 1;
      return;
    end
    seen = 1;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [63:0] idx;
    idx = pos;
    if (pos < 64'(wavhv_pkg::PosMax)) pos++;
    case (ph)
      PhRiff: begin
        tag = {tag[23:0], b};
        if (idx >= 4 && idx < 8) fa = {b, fa[31:8]};
        if (idx == 3 && tag != wavhv_pkg::TagRiff) bad = 1;
        if (idx == wavhv_pkg::RiffHdrBytes - 1) begin
          if (tag != wavhv_pkg::TagWave || fa < 4) begin
            bad = 1;
            return;
          end
          rend = 64'(fa) + 8;
          next_chunk();
        end
      end
      PhChdr: begin
        if (rem > 4) tag = {tag[23:0], b};
        else fa = {b, fa[31:8]};
        rem--;
        if (rem == 0) end_chunk_header();
      end
      PhFmt: begin
        if (fa < wavhv_pkg::FmtMinBytes) begin
          ff[fa[3:0]] = b;
          fa++;
          if (fa == wavhv_pkg::FmtMinBytes) check_format();
        end
        if (rem > 0) rem--;
        if (!bad && rem == 0) next_chunk();
      end
      PhSkip: begin
        if (rem > 0) rem--;
        if (rem == 0) next_chunk();
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t verdict_now();
    verdict_t v;
    logic [31:0] align, brate;
    v = '{default: '0};
    align = ff16(12);
    brate = ff32(8);
    if (!bad && ph == PhDone && seen && dsize != 0 && align != 0 && brate != 0 &&
        dsize % align == 0) begin
      v.ok = 1;
      v.fmt.channels = ff16(2);
      v.fmt.sample_rate = ff32(4);
      v.fmt.byte_rate = brate;
      v.fmt.block_align = align[15:0];
      v.fmt.bits_per_sample = ff16(14);
      v.fmt.data_bytes = dsize;
      v.dur = 48'(({32'h0, dsize} << 16) / 64'(brate));
    end
    return v;
  endfunction

  always @(posedge clk_i) begin : monitor
    verdict_t v, w;
    int t;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          report("unexpected verdict", m_axis_tdata[63:0], 64'(0));
        end else begin
          w = verdicts_due.pop_front();
          if (m_axis_tdata[0] != w.ok)
            report("ok", 64'(m_axis_tdata[0]), 64'(w.ok));
          if (m_axis_tdata[16:1] != w.fmt.channels)
            report("channels", 64'(m_axis_tdata[16:1]), 64'(w.fmt.channels));
          if (m_axis_tdata[48:17] != w.fmt.sample_rate)
            report("sample_rate", 64'(m_axis_tdata[48:17]), 64'(w.fmt.sample_rate));
          if (m_axis_tdata[80:49] != w.fmt.byte_rate)
            report("byte_rate", 64'(m_axis_tdata[80:49]), 64'(w.fmt.byte_rate));
          if (m_axis_tdata[96:81] != w.fmt.block_align)
            report("block_align", 64'(m_axis_tdata[96:81]), 64'(w.fmt.block_align));
          if (m_axis_tdata[112:97] != w.fmt.bits_per_sample)
            report("bits_per_sample", 64'(m_axis_tdata[112:97]),
                   64'(w.fmt.bits_per_sample));
          if (m_axis_tdata[144:113] != w.fmt.data_bytes)
            report("data_bytes", 64'(m_axis_tdata[144:113]), 64'(w.fmt.data_bytes));
          if (m_axis_tdata[192:145] != w.dur)
            report("duration_q16", 64'(m_axis_tdata[192:145]), 64'(w.dur));
          if (m_axis_tdata[0]) n_valid++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_bytes++;
        if (!bad) parse_byte(s_axis_tdata);
        if (s_axis_tlast) begin
          v = verdict_now();
          t = typed_ok.size() ? typed_ok.pop_front() : -1;
          if (t == 0) v = '{default: '0};
          else if (t == 1) v.ok = 1'b1;
          verdicts_due.push_back(v);
          parser_clear();
        end
      end
    end
  end

  function automatic void push_tag(ref logic [7:0] q[$], input logic [31:0] t);
    for (int i = 3; i >= 0; i--) q.push_back(t[8*i +: 8]);
  endfunction

  function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_chunk(ref logic [7:0] q[$], input logic [31:0] t, input int len);
    push_tag(q, t);
    push_le(q, len, 4);
    for (int i = 0; i < len + (len & 1); i++) q.push_back(8'($urandom));
  endfunction

  function automatic wav_spec_t base_spec();
    wav_spec_t s;
    s.head_tag = wavhv_pkg::TagRiff; s.wave_tag = wavhv_pkg::TagWave;
    s.p_force = -1; s.p_adj = 0;
    s.code = 1; s.ch = 2; s.bits = 16; s.align = 4; s.rate = 8000; s.brate = 32000;
    s.fmt_len = 16; s.data_len = 8; s.junk_len = -1;
    s.small_fmt = 0; s.dup_data = 0; s.no_fmt = 0;
    s.keep = -1; s.tail = 0; s.flip = 0;
    return s;
  endfunction

  function automatic void build_wav(input wav_spec_t s, ref logic [7:0] q[$]);
    logic [7:0] body[$];
    int p;
    if (s.small_fmt) push_chunk(body, wavhv_pkg::TagFmt, 14);
    if (s.junk_len >= 0) push_chunk(body, $urandom, s.junk_len);
    if (!s.no_fmt) begin
      push_tag(body, wavhv_pkg::TagFmt);
      push_le(body, s.fmt_len, 4);
      push_le(body, 32'(s.code), 2); push_le(body, 32'(s.ch), 2);
      push_le(body, s.rate, 4); push_le(body, s.brate, 4);
      push_le(body, 32'(s.align), 2); push_le(body, 32'(s.bits), 2);
      for (int i = 16; i < s.fmt_len + (s.fmt_len & 1); i++) body.push_back(8'($urandom));
    end
    if (s.dup_data) push_chunk(body, wavhv_pkg::TagData, 2);
    push_chunk(body, wavhv_pkg::TagData, s.data_len);
    p = (s.p_force >= 0) ? s.p_force : 4 + body.size() + s.p_adj;
    q.delete();
    push_tag(q, s.head_tag);
    push_le(q, p, 4);
    push_tag(q, s.wave_tag);
    q = {q, body};
    for (int i = 0; i < s.tail; i++) q.push_back(8'($urandom));
    if (s.keep > 0 && s.keep < q.size()) q = q[0:s.keep-1];
    if (s.flip) q[$urandom_range(0, q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  function automatic wav_spec_t random_spec();
    wav_spec_t s;
    logic [63:0] r;
    s = base_spec();
    s.ch = 16'($urandom_range(1, 4));
    s.bits = 16'(8 * $urandom_range(1, 4));
    s.align = s.ch * (s.bits / 16'd8);
    s.rate = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom;
    r = 64'(s.rate) * 64'(s.align);
    s.brate = r[31:0];
    s.fmt_len = $urandom_range(0, 3) ? 16 : $urandom_range(17, 21);
    s.data_len = s.align * $urandom_range(1, 5);
    s.junk_len = $urandom_range(0, 1) ? $urandom_range(0, 9) : -1;
    s.small_fmt = $urandom_range(0, 7) == 0;
    case ($urandom_range(0, 19))
      0: s.code = 16'($urandom);
      1: s.brate++;
      2: s.align++;
      3: s.bits = 16'($urandom);
      4: s.data_len++;
      5: s.dup_data = 1;
      6: s.p_adj = $urandom_range(0, 1) ? -2 : 2;
      7: s.keep = $urandom_range(1, 40);
      8: s.flip = 1;
      9: s.no_fmt = 1;
      10: s.data_len = 0;
      11: s.tail = $urandom_range(1, 6);
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_file(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= q[i];
      s_axis_tlast <= (i == q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    n_files++;
  endtask

  initial begin : receiver
    m_axis_tready <= 1'b1;
    forever begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    rows[$];
    wav_spec_t   s;
    logic [7:0]  q[$];
    int          k;
    rows = '{'{0, 0}, '{1, 0}, '{2, 0}, '{3, 0}, '{4, 0}, '{5, -1}, '{6, -1},
             '{7, 0}, '{8, 0}, '{9, 0}, '{10, 0}, '{11, 0}, '{12, 0}, '{13, 0},
             '{14, 0}, '{15, -1}, '{16, -1}, '{17, 0}};
    parser_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      s = base_spec();
      case (rows[r].name_ix)
        0: s.keep = 1;
        1: s.head_tag = 32'h52494658;
        2: begin s.p_force = 3; s.keep = 12; end
        3: s.wave_tag = 32'h57415646;
        4: s.keep = 40;
        5: begin s.ch = 1; s.bits = 8; s.align = 1; s.rate = 1; s.brate = 1; s.data_len = 1; end
        6: begin s.ch = 1; s.bits = 32; s.rate = 32'h3FFFFFFF; s.brate = 32'hFFFFFFFC; end
        7: begin s.ch = 1; s.bits = 32; s.rate = 32'h40000000; s.brate = 0; end
        8: s.code = 3;
        9: s.align = 3;
        10: s.no_fmt = 1;
        11: s.data_len = 0;
        12: s.dup_data = 1;
        13: begin s.p_adj = 2; s.tail = 2; end
        14: s.p_adj = -2;
        15: s.small_fmt = 1;
        16: s.tail = 5;
        17: s.data_len = 6;
        default: ;
      endcase
      build_wav(s, q);
      typed_ok.push_back(rows[r].ok_typed);
      send_file(q);
    end
    k = 0;
    while (n_bytes < 1800 || k < 4) begin
      if (k == 3) hold_long = 1;
      if (n_bytes > 1550) calm = 1;
      build_wav(random_spec(), q);
      typed_ok.push_back(-1);
      send_file(q);
      k++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("Streamed %0d files (%0d bytes); %0d were accepted as PCM WAV.",
             n_files, n_bytes, n_valid);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
